// ----- hdl/tsmq_pkg.sv -----
// ----------------------------------------------------------------------------
// tsmq_pkg: shared types and constants for the timestamp merge queues
// Function codes, register indexes and the front-to-back command word.
// ----------------------------------------------------------------------------
package tsmq_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned DevW    = 3;
  localparam int unsigned StampW  = 64;
  localparam int unsigned PayW    = 32;
  localparam int unsigned ActW    = 4;
  localparam int unsigned WinW    = 40;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ActW-1:0] ActReset = 4'd8;
  localparam logic [WinW-1:0] WinReset = 40'd3000000000;

  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_END  = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVE = 1'b0,
    REG_WINDOW = 1'b1
  } reg_e;

  // One accepted command as it travels from front to back.
  typedef struct packed {
    func_e             func;
    logic [DevW-1:0]   device;
    logic [StampW-1:0] stamp;
    logic [PayW-1:0]   payload;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_READ,
    BK_DONE
  } back_state_e;

endpackage

// ----- hdl/tsmq_front.sv -----
// ----------------------------------------------------------------------------
// tsmq_front: command intake
// Captures start commands into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module tsmq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  tsmq_pkg::func_e func_i,
  input  logic [2:0]      device_i,
  input  logic [63:0]     stamp_i,
  input  logic [31:0]     payload_i,
  output logic            busy,
  output logic            cmd_valid_o,
  output tsmq_pkg::cmd_t  cmd_o,
  input  logic            cmd_pop_i
);

  tsmq_pkg::cmd_t q_mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push;

  assign busy        = (cnt_q == 2'd2);
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= '{func: func_i, device: device_i,
                             stamp: stamp_i, payload: payload_i};
    end
  end

endmodule

// ----- hdl/tsmq_back.sv -----
// ----------------------------------------------------------------------------
// tsmq_back: queue engine
// Per-device FIFOs in one record memory; pop scans heads one device a cycle.
// ----------------------------------------------------------------------------
module tsmq_back #(
  parameter int unsigned DEVICES      = 8,
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  tsmq_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  input  logic [3:0]        active_i,
  input  logic [39:0]       window_i,
  output logic              res_strobe_o,
  output logic              out_valid_o,
  output logic [2:0]        out_device_o,
  output logic [63:0]       out_stamp_o,
  output logic [31:0]       out_payload_o,
  output logic              fetch_req_o,
  output logic              ended_o,
  output logic              dropped_o
);

  localparam int unsigned DevIdxW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int unsigned PtrW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned SumW    = PtrW + 1;
  localparam int unsigned CntW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned Slots   = DEVICES * QUEUE_DEPTH;
  localparam int unsigned SlotW   = $clog2(Slots);
  localparam int unsigned NW      = $clog2(DEVICES + 1);

  logic [63:0]           st_mem [Slots];
  logic [PAYLOAD_BITS-1:0] pl_mem [Slots];

  logic [CntW-1:0] cnt_q  [DEVICES];
  logic [PtrW-1:0] head_q [DEVICES];
  logic [63:0]     tail_q, last_q;
  logic            started_q, finished_q;

  tsmq_pkg::back_state_e state_q, state_d;
  logic [NW-1:0]         scan_q;
  logic                  found_q;
  logic [DevIdxW-1:0]    best_q;
  logic [63:0]           best_st_q;
  logic [63:0]           rd_st_q;
  logic [PAYLOAD_BITS-1:0] rd_pl_q;

  logic [NW-1:0] n_live;
  always_comb begin
    if (active_i == 4'd0) n_live = NW'(1);
    else if ({28'd0, active_i} > DEVICES) n_live = NW'(DEVICES);
    else n_live = NW'(active_i);
  end

  logic [DevIdxW-1:0] cdev;
  logic               dev_ok;
  assign dev_ok = ({29'd0, cmd_i.device} < {{(32-NW){1'b0}}, n_live});
  assign cdev   = DevIdxW'(cmd_i.device);

  logic push_ok;
  assign push_ok = !finished_q && dev_ok &&
                   (cnt_q[cdev] < CntW'(QUEUE_DEPTH));

  // Write position wraps at the queue depth, which need not be a power of two.
  logic [SumW-1:0]  wsum;
  logic [PtrW-1:0]  wpos;
  logic [SlotW-1:0] wslot, scan_slot, best_slot;
  logic [DevIdxW-1:0] sdev;
  assign wsum      = {1'b0, head_q[cdev]} + SumW'(cnt_q[cdev]);
  assign wpos      = (wsum >= SumW'(QUEUE_DEPTH)) ? PtrW'(wsum - SumW'(QUEUE_DEPTH))
                                                  : PtrW'(wsum);
  assign wslot     = SlotW'(cdev * QUEUE_DEPTH + wpos);
  assign sdev      = DevIdxW'(scan_q);
  assign scan_slot = SlotW'(sdev * QUEUE_DEPTH + head_q[sdev]);
  assign best_slot = SlotW'(best_q * QUEUE_DEPTH + head_q[best_q]);

  // Status after update, computed from registered state.
  logic any_empty, all_empty, behind;
  logic [64:0] lim;
  always_comb begin
    any_empty = 1'b0;
    all_empty = 1'b1;
    for (int d = 0; d < DEVICES; d++) begin
      if (NW'(d) < n_live) begin
        if (cnt_q[d] == '0) any_empty = 1'b1;
        else all_empty = 1'b0;
      end
    end
    lim    = {1'b0, last_q} + {25'd0, window_i};
    behind = ({1'b0, tail_q} < lim);
  end

  logic res_q, res_v_q, drop_q;
  logic [2:0] res_dev_q;

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      tsmq_pkg::BK_IDLE: if (cmd_valid_i) begin
        cmd_pop_o = 1'b1;
        if (cmd_i.func == tsmq_pkg::FUNC_POP) state_d = tsmq_pkg::BK_SCAN;
        else state_d = tsmq_pkg::BK_DONE;
      end
      tsmq_pkg::BK_SCAN: if (scan_q + NW'(1) >= n_live) state_d = tsmq_pkg::BK_READ;
      tsmq_pkg::BK_READ: state_d = tsmq_pkg::BK_DONE;
      tsmq_pkg::BK_DONE: state_d = tsmq_pkg::BK_IDLE;
      default: state_d = tsmq_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tsmq_pkg::BK_IDLE && cmd_valid_i &&
        cmd_i.func == tsmq_pkg::FUNC_PUSH && push_ok) begin
      st_mem[wslot] <= cmd_i.stamp;
      pl_mem[wslot] <= PAYLOAD_BITS'(cmd_i.payload);
    end
    rd_st_q <= st_mem[scan_slot];
    rd_pl_q <= pl_mem[best_slot];
  end

  // Scan timing: cycle k reads head of device scan_q; compare next cycle.
  logic cmp_v_q;
  logic [DevIdxW-1:0] cmp_dev_q;
  logic cmp_ne_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tsmq_pkg::BK_IDLE;
      for (int d = 0; d < DEVICES; d++) begin
        cnt_q[d]  <= '0;
        head_q[d] <= '0;
      end
      tail_q     <= '0;
      last_q     <= '0;
      started_q  <= 1'b0;
      finished_q <= 1'b0;
      scan_q     <= '0;
      found_q    <= 1'b0;
      best_q     <= '0;
      best_st_q  <= '0;
      cmp_v_q    <= 1'b0;
      cmp_dev_q  <= '0;
      cmp_ne_q   <= 1'b0;
      res_q      <= 1'b0;
      res_v_q    <= 1'b0;
      res_dev_q  <= '0;
      drop_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= 1'b0;
      cmp_v_q <= 1'b0;
      // Compare stage for the previous scan read.
      if (cmp_v_q && cmp_ne_q && (!found_q || rd_st_q < best_st_q)) begin
        found_q   <= 1'b1;
        best_q    <= cmp_dev_q;
        best_st_q <= rd_st_q;
      end
      case (state_q)
        tsmq_pkg::BK_IDLE: if (cmd_valid_i) begin
          scan_q  <= '0;
          found_q <= 1'b0;
          res_v_q <= 1'b0;
          drop_q  <= 1'b0;
          case (cmd_i.func)
            tsmq_pkg::FUNC_PUSH: begin
              if (push_ok) begin
                cnt_q[cdev] <= cnt_q[cdev] + CntW'(1);
                started_q   <= 1'b1;
                if (!started_q || tail_q < cmd_i.stamp) tail_q <= cmd_i.stamp;
              end else begin
                drop_q <= 1'b1;
              end
            end
            tsmq_pkg::FUNC_END: finished_q <= 1'b1;
            default: ;
          endcase
        end
        tsmq_pkg::BK_SCAN: begin
          cmp_v_q   <= 1'b1;
          cmp_dev_q <= sdev;
          cmp_ne_q  <= (cnt_q[sdev] != '0);
          scan_q    <= scan_q + NW'(1);
        end
        tsmq_pkg::BK_READ: ;
        tsmq_pkg::BK_DONE: begin
          res_q <= 1'b1;
          if (found_q) begin
            res_v_q           <= 1'b1;
            res_dev_q         <= 3'(best_q);
            head_q[best_q]    <= (head_q[best_q] == PtrW'(QUEUE_DEPTH - 1)) ? '0
                                 : head_q[best_q] + PtrW'(1);
            cnt_q[best_q]     <= cnt_q[best_q] - CntW'(1);
            last_q            <= best_st_q;
            found_q           <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Result cycle: status reflects state updated at the end of BK_DONE.
  assign res_strobe_o  = res_q;
  assign out_valid_o   = res_v_q;
  assign out_device_o  = res_v_q ? res_dev_q : 3'd0;
  assign out_stamp_o   = res_v_q ? last_q : 64'd0;
  assign out_payload_o = res_v_q ? 32'(rd_pl_q) : 32'd0;
  assign dropped_o     = drop_q;
  assign fetch_req_o   = !finished_q && any_empty && (!started_q || behind);
  assign ended_o       = finished_q && all_empty;

endmodule

// ----- hdl/timestamp_merge_queues_core.sv -----
// ----------------------------------------------------------------------------
// timestamp_merge_queues_core: k-way merge of per-device record queues
// Push/pop/end commands; pop returns the earliest head over active devices.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  command   | start / busy           | func, device, stamp, payload
//  result    | done strobe, no stall  | out_* , fetch_req, ended, dropped
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A push or end command goes from the command queue through the engine's
// idle and done states to its result; a pop runs a head scan over the active
// devices, one head per cycle from the record memory, and then a read state.
// Reset clears all queue counts and pointers; the record memory is not cleared.
// The receiver cannot stall; busy rises only when the two-entry command
// queue between intake and engine is full.
module timestamp_merge_queues_core #(
  parameter int unsigned DEVICES      = 8,
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [2:0]  device_i,
  input  logic [63:0] stamp_i,
  input  logic [31:0] payload_i,
  output logic        done_o,
  output logic        out_valid_o,
  output logic [2:0]  out_device_o,
  output logic [63:0] out_stamp_o,
  output logic [31:0] out_payload_o,
  output logic        fetch_req_o,
  output logic        ended_o,
  output logic        dropped_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [3:0]  active_q;
  logic [39:0] window_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= tsmq_pkg::ActReset;
      window_q <= tsmq_pkg::WinReset;
    end else if (cfg_valid_i) begin
      case (tsmq_pkg::reg_e'(cfg_index_i))
        tsmq_pkg::REG_ACTIVE: active_q <= cfg_data_i[3:0];
        tsmq_pkg::REG_WINDOW: window_q <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  logic           cmd_valid, cmd_pop;
  tsmq_pkg::cmd_t cmd;

  tsmq_front u_front (
    .clk_i, .rst_ni, .start,
    .func_i(tsmq_pkg::func_e'(func_i)), .device_i, .stamp_i, .payload_i,
    .busy, .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  tsmq_back #(
    .DEVICES(DEVICES), .QUEUE_DEPTH(QUEUE_DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .active_i(active_q), .window_i(window_q),
    .res_strobe_o(done_o), .out_valid_o, .out_device_o, .out_stamp_o,
    .out_payload_o, .fetch_req_o, .ended_o, .dropped_o
  );

endmodule

// ----- hdl/tsmq_checker.sv -----
// ----------------------------------------------------------------------------
// tsmq_checker: port-level checks for timestamp_merge_queues_core
// Watches result strobe and fields over time.
// ----------------------------------------------------------------------------
module tsmq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        done_o,
  input logic        out_valid_o,
  input logic        dropped_o,
  input logic        ended_o,
  input logic        fetch_req_o,
  input logic [63:0] out_stamp_o,
  input logic [31:0] out_payload_o
);

  a_pop_not_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(out_valid_o && dropped_o)) else $error("pop and drop together");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");

  a_ended_no_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ended_o) |-> !fetch_req_o) else $error("fetch after end");

  a_empty_pop_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_valid_o) |-> (out_payload_o == 32'd0)) else $error("stale payload");

  a_empty_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_valid_o) |-> (out_stamp_o == 64'd0)) else $error("stale stamp");

endmodule

bind timestamp_merge_queues_core tsmq_checker u_tsmq_checker (
  .clk_i, .rst_ni, .done_o, .out_valid_o, .dropped_o,
  .ended_o, .fetch_req_o, .out_stamp_o, .out_payload_o
);

// ----- dv/timestamp_merge_queues_core_tb.sv -----
// ----------------------------------------------------------------------------
// timestamp_merge_queues_core_tb: self-checking bench for the merge queues
// Drives push/pop/end/nop commands under several register settings, predicts
// every result with an in-bench queue model and compares field by field.
// ----------------------------------------------------------------------------
module timestamp_merge_queues_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NDEV  = 8;
  localparam int unsigned DEPTH = 16;

  typedef struct packed {
    logic                        valid;
    logic [tsmq_pkg::DevW-1:0]   device;
    logic [tsmq_pkg::StampW-1:0] stamp;
    logic [tsmq_pkg::PayW-1:0]   payload;
    logic                        fetch_req;
    logic                        ended;
    logic                        dropped;
  } merge_res_t;

  // Queue model plus a queue of expected results.
  class merge_scoreboard;
    logic [tsmq_pkg::StampW-1:0] rec_stamp [NDEV][DEPTH];
    logic [tsmq_pkg::PayW-1:0]   rec_pay   [NDEV][DEPTH];
    int unsigned                 cnt [NDEV];
    int unsigned                 head [NDEV];
    logic [tsmq_pkg::StampW-1:0] tail_ts, last_rd;
    bit                          began, fin;
    logic [tsmq_pkg::ActW-1:0]   act;
    logic [tsmq_pkg::WinW-1:0]   win;
    merge_res_t                  pending[$];
    int unsigned                 errors, pops_hit, drops, checked;

    function new();
      foreach (cnt[d]) begin
        cnt[d] = 0;
        head[d] = 0;
      end
      tail_ts = '0; last_rd = '0; began = 0; fin = 0;
      act = tsmq_pkg::ActReset; win = tsmq_pkg::WinReset;
      errors = 0; pops_hit = 0; drops = 0; checked = 0;
    endfunction

    function void write_reg(tsmq_pkg::reg_e idx, logic [63:0] data);
      if (idx == tsmq_pkg::REG_ACTIVE) act = data[tsmq_pkg::ActW-1:0];
      else win = data[tsmq_pkg::WinW-1:0];
    endfunction

    function int unsigned live();
      if (act == 0) return 1;
      if (act > NDEV) return NDEV;
      return act;
    endfunction

    function void note_cmd(tsmq_pkg::func_e f, logic [tsmq_pkg::DevW-1:0] dev,
                           logic [tsmq_pkg::StampW-1:0] st,
                           logic [tsmq_pkg::PayW-1:0] pl);
      merge_res_t r;
      int unsigned n, best, pos;
      bit found, any_e, all_e;
      logic [tsmq_pkg::StampW:0] lim;
      n = live();
      r = '0;
      found = 0;
      best = 0;
      case (f)
        tsmq_pkg::FUNC_PUSH: begin
          if (fin || dev >= n || cnt[dev] >= DEPTH) begin
            r.dropped = 1;
          end else begin
            pos = (head[dev] + cnt[dev]) % DEPTH;
            rec_stamp[dev][pos] = st;
            rec_pay[dev][pos] = pl;
            cnt[dev]++;
            if (!began) begin
              began = 1;
              tail_ts = st;
            end else if (tail_ts < st) tail_ts = st;
          end
        end
        tsmq_pkg::FUNC_POP: begin
          for (int d = 0; d < n; d++)
            if (cnt[d] != 0 &&
                (!found || rec_stamp[d][head[d]] < rec_stamp[best][head[best]])) begin
              found = 1;
              best = d;
            end
          if (found) begin
            r.valid = 1;
            r.device = 3'(best);
            r.stamp = rec_stamp[best][head[best]];
            r.payload = rec_pay[best][head[best]];
            head[best] = (head[best] + 1) % DEPTH;
            cnt[best]--;
            last_rd = r.stamp;
          end
        end
        tsmq_pkg::FUNC_END: fin = 1;
        default: ;
      endcase
      any_e = 0;
      all_e = 1;
      for (int d = 0; d < n; d++) begin
        if (cnt[d] == 0) any_e = 1;
        else all_e = 0;
      end
      lim = {1'b0, last_rd} + {25'd0, win};
      if (fin) r.fetch_req = 0;
      else if (!began) r.fetch_req = any_e;
      else r.fetch_req = any_e && ({1'b0, tail_ts} < lim);
      r.ended = fin && all_e;
      pending.push_back(r);
    endfunction

    function void check_result(merge_res_t act_r);
      merge_res_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, act_r);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.valid) pops_hit++;
      if (e.dropped) drops++;
      if (act_r.valid !== e.valid || act_r.device !== e.device ||
          act_r.stamp !== e.stamp || act_r.payload !== e.payload ||
          act_r.fetch_req !== e.fetch_req || act_r.ended !== e.ended ||
          act_r.dropped !== e.dropped) begin
        $display("%0t: mismatch expected %p actual %p", $time, e, act_r);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              start = 0;
  logic              busy;
  logic [1:0]        func_i = '0;
  logic [2:0]        device_i = '0;
  logic [63:0]       stamp_i = '0;
  logic [31:0]       payload_i = '0;
  logic              done_o, out_valid_o, fetch_req_o, ended_o, dropped_o;
  logic [2:0]        out_device_o;
  logic [63:0]       out_stamp_o;
  logic [31:0]       out_payload_o;
  logic              cfg_valid_i = 0;
  logic              cfg_ready_o;
  logic              cfg_index_i = 0;
  logic [63:0]       cfg_data_i = '0;

  merge_scoreboard sb = new();
  bit calm;        // no idle gaps while set
  int unsigned sent;

  always #2 clk_i = ~clk_i;

  timestamp_merge_queues_core uut (.*);

  // Results come as one-cycle strobes; sample at the edge that ends them.
  always @(posedge clk_i)
    if (rst_ni && done_o)
      sb.check_result('{out_valid_o, out_device_o, out_stamp_o, out_payload_o,
                        fetch_req_o, ended_o, dropped_o});

  // One command transfer, with random idle cycles before it. start stays
  // high after a transfer; an idle cycle or a drain takes it low.
  task automatic send_cmd(tsmq_pkg::func_e f, logic [2:0] dev, logic [63:0] st,
                          logic [31:0] pl);
    while (!calm && $urandom_range(99) < 10) begin
      start <= 0;
      @(posedge clk_i);
    end
    start <= 1;
    func_i <= f;
    device_i <= dev;
    stamp_i <= st;
    payload_i <= pl;
    do @(posedge clk_i); while (busy);
    sb.note_cmd(f, dev, st, pl);
    sent++;
  endtask

  // Take start low, wait for all outstanding results, then idle on.
  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(tsmq_pkg::reg_e idx, logic [63:0] data);
    drain();
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    sb.write_reg(idx, data);
  endtask

  // Stamps close together so ties and ordering matter; rarely huge.
  function automatic logic [63:0] rnd_stamp(logic [63:0] base);
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: return '1;
      2: return 64'd0;
      default: return base + $urandom_range(4000);
    endcase
  endfunction

  // One phase: mostly push/pop traffic in random proportion, an end marker
  // near the end, then seven more random commands.
  task automatic random_phase(int unsigned items, int unsigned push_pct,
                              logic [63:0] base);
    int unsigned k;
    for (k = 0; k < items; k++) begin
      if (k == items - 8) send_cmd(tsmq_pkg::FUNC_END, 0, 0, 0);
      else if ($urandom_range(99) < 3)
        send_cmd(tsmq_pkg::FUNC_NOP, 3'($urandom), {$urandom, $urandom}, $urandom);
      else if ($urandom_range(99) < push_pct)
        send_cmd(tsmq_pkg::FUNC_PUSH, 3'($urandom), rnd_stamp(base + k * 100), $urandom);
      else send_cmd(tsmq_pkg::FUNC_POP, 3'($urandom), {$urandom, $urandom}, $urandom);
    end
  endtask

  initial begin
    calm = 1;
    sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, ties, empty pop, overflow, func 3, end and drain.
    send_cmd(tsmq_pkg::FUNC_POP, 0, 0, 0);
    send_cmd(tsmq_pkg::FUNC_NOP, 7, '1, '1);
    send_cmd(tsmq_pkg::FUNC_PUSH, 7, '1, '1);
    send_cmd(tsmq_pkg::FUNC_PUSH, 0, 64'd5, 32'h0);
    send_cmd(tsmq_pkg::FUNC_PUSH, 3, 64'd5, 32'hA5A5_5A5A);
    send_cmd(tsmq_pkg::FUNC_PUSH, 1, 64'd0, 32'h5A5A_A5A5);
    for (int i = 0; i < 17; i++) send_cmd(tsmq_pkg::FUNC_PUSH, 2, 64'(i), 32'(i));
    repeat (5) send_cmd(tsmq_pkg::FUNC_POP, 0, 0, 0);
    send_cmd(tsmq_pkg::FUNC_END, 0, 0, 0);
    send_cmd(tsmq_pkg::FUNC_PUSH, 4, 1, 1);
    repeat (20) send_cmd(tsmq_pkg::FUNC_POP, 0, 0, 0);
    drain();

    // No reset comes between phases; the block keeps "finished" after the first
    // end, so later phases exercise post-end behaviour with every push refused.
    // Register settings: extreme and small device counts, extremes of the window.
    write_reg(tsmq_pkg::REG_ACTIVE, 64'd0);
    write_reg(tsmq_pkg::REG_WINDOW, 64'd0);
    random_phase(150, 60, 64'd1000);
    write_reg(tsmq_pkg::REG_ACTIVE, 64'd15);
    write_reg(tsmq_pkg::REG_WINDOW, 64'hFFFF_FFFF_FFFF_FFFF);
    random_phase(150, 55, 64'hFFFF_FFFF_FFFF_0000);
    calm = 0;
    write_reg(tsmq_pkg::REG_ACTIVE, 64'd3);
    write_reg(tsmq_pkg::REG_WINDOW, 64'd2500);
    random_phase(300, 60, 64'd0);
    write_reg(tsmq_pkg::REG_ACTIVE, 64'd1);
    random_phase(250, 50, 64'd77);
    write_reg(tsmq_pkg::REG_ACTIVE, 64'd8);
    write_reg(tsmq_pkg::REG_WINDOW, {$urandom, $urandom});
    random_phase(350, 60, {$urandom, 32'd0});
    drain();

    $display("Covered %0d commands, %0d results, %0d records popped, %0d pushes refused.",
             sent, sb.checked, sb.pops_hit, sb.drops);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("timestamp_merge_queues_core_tb: PASS");
    end else begin
      $display("timestamp_merge_queues_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timestamp_merge_queues_core_tb: FAIL");
    $finish;
  end

endmodule
